// ===== sv/tbps_pkg.sv =====
// Shared types and constants for the token bucket packet shaper.
`default_nettype none

package tbps_pkg;

   // Waiting-packet queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Command codes
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_ARRIVE = 1'b1;

   // Result event codes
   typedef enum logic [2:0] {
      EV_DROP_BIG   = 3'd0,
      EV_QUEUED     = 3'd1,
      EV_RELEASED   = 3'd2,
      EV_TOKEN_ADD  = 3'd3,
      EV_TOKEN_DROP = 3'd4,
      EV_QUEUE_FULL = 3'd5
   } event_type;

   // Input beat
   typedef struct packed {
      logic        cmd;
      logic [15:0] pkt_id;
      logic [7:0]  token_cost;
   } req_type;

   // Result beat
   typedef struct packed {
      event_type   event_res;
      logic [15:0] packet_id_res;
      logic [7:0]  tokens_left;
      logic        last;
   } rsp_type;

   // One queue entry as stored in memory
   typedef struct packed {
      logic [15:0] pkt_id;
      logic [7:0]  need;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Queue memory access from the controller
   typedef struct packed {
      logic             wr_en;
      logic [PTR_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [PTR_W-1:0] rd_addr;
   } mem_req_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// ===== sv/tbps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/tbps_ctrl.sv =====
// Shaper controller: bucket level, queue pointers, decision FSM, result register.
`default_nettype none

module tbps_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire tbps_pkg::req_type    req_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [7:0]           csr_data,
   output logic                      rsp_strobe,
   output tbps_pkg::rsp_type         rsp_data,
   output tbps_pkg::mem_req_type     mem_req,
   input  wire tbps_pkg::entry_type  mem_rd_data
);

   import tbps_pkg::*;

   state_type        state_ff, state_in;
   logic [7:0]       cap_ff, cap_in;
   logic [7:0]       level_ff, level_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          req_ff, req_in;
   rsp_type          pend_ff, pend_in;
   rsp_type          rsp_ff, rsp_in;
   logic             strobe_ff, strobe_in;
   logic             releasable;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] i);
      logic [PTR_W-1:0] r;
      if (i == PTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + PTR_W'(1);
      end
      return r;
   endfunction

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cap_ff    <= 8'd10;
         level_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         level_ff  <= level_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Head entry can go out if the bucket covers it
   assign releasable = (count_ff != '0) && (level_ff >= mem_rd_data.need);

   // Next state and datapath
   always_comb begin
      state_in  = state_ff;
      cap_in    = (csr_valid) ? csr_data : cap_ff;
      level_in  = level_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      req_in    = req_ff;
      pend_in   = pend_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;

      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = tail_ff;
      mem_req.wr_data = '{pkt_id: req_ff.pkt_id, need: req_ff.token_cost};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.cmd == CMD_ARRIVE) begin
                  state_in = ST_ARRIVE;
               end else begin
                  // token tick: result held until the head decision is known
                  pend_in.packet_id_res = '0;
                  pend_in.last          = 1'b0;
                  if (level_ff >= cap_ff) begin
                     pend_in.event_res   = EV_TOKEN_DROP;
                     pend_in.tokens_left = level_ff;
                  end else begin
                     level_in            = level_ff + 8'd1;
                     pend_in.event_res   = EV_TOKEN_ADD;
                     pend_in.tokens_left = level_ff + 8'd1;
                  end
                  state_in = ST_DRAIN;
               end
            end
         end

         ST_ARRIVE: begin
            strobe_in            = 1'b1;
            rsp_in.packet_id_res = req_ff.pkt_id;
            rsp_in.tokens_left   = level_ff;
            rsp_in.last          = 1'b1;
            if (req_ff.token_cost > cap_ff) begin
               rsp_in.event_res = EV_DROP_BIG;
            end else if ((count_ff != '0) || (level_ff < req_ff.token_cost)) begin
               if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  rsp_in.event_res = EV_QUEUE_FULL;
               end else begin
                  mem_req.wr_en    = 1'b1;
                  tail_in          = next_slot(tail_ff);
                  count_in         = count_ff + CNT_W'(1);
                  rsp_in.event_res = EV_QUEUED;
               end
            end else begin
               level_in           = level_ff - req_ff.token_cost;
               rsp_in.event_res   = EV_RELEASED;
               rsp_in.tokens_left = level_ff - req_ff.token_cost;
            end
            state_in = ST_IDLE;
         end

         ST_DRAIN: begin
            // send the held beat; it is last unless the head goes out now
            strobe_in   = 1'b1;
            rsp_in      = pend_ff;
            rsp_in.last = !releasable;
            if (releasable) begin
               level_in              = level_ff - mem_rd_data.need;
               pend_in.event_res     = EV_RELEASED;
               pend_in.packet_id_res = mem_rd_data.pkt_id;
               pend_in.tokens_left   = level_ff - mem_rd_data.need;
               pend_in.last          = 1'b0;
               head_in               = next_slot(head_ff);
               count_in              = count_ff - CNT_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // read the entry that will be head next cycle
      mem_req.rd_addr = head_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/token_bucket_packet_shaper_top.sv =====
// Top level of the token bucket packet shaper: controller plus queue memory.
// After start is taken, the first beat is strobed from the result register.
// Arrival: busy for one cycle, one result. Tick: one result per cycle,
// first the token result, then one per packet released while the bucket
// covers the head, paced by one head read per cycle from the queue memory.
// Reset: synchronous; bucket empty, queue empty, capacity back to 10.
`default_nettype none

module token_bucket_packet_shaper_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tbps_pkg::req_type req_data,
   output logic                   rsp_strobe,
   output tbps_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data
);

   import tbps_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rd_data;

   // Decision logic and bucket state
   tbps_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   // Waiting packet queue storage
   tbps_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== sv/tbps_checker.sv =====
// Port-level checks for the shaper top level, attached by bind.
`default_nettype none

module tbps_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire tbps_pkg::rsp_type rsp_data
);

   import tbps_pkg::*;

   // A taken command makes the block busy, with no beat in that cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("command taken but block not busy or beat out early");

   // Beats of one tick come back to back until last
   a_burst_gapless: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> rsp_strobe)
      else $error("gap inside a result burst");

   // Arrival outcomes are single-beat
   a_arrival_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.event_res == EV_DROP_BIG ||
                      rsp_data.event_res == EV_QUEUED ||
                      rsp_data.event_res == EV_QUEUE_FULL)) |-> rsp_data.last)
      else $error("arrival result without last");

   // Token events carry no packet id
   a_token_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.event_res == EV_TOKEN_ADD ||
                      rsp_data.event_res == EV_TOKEN_DROP))
         |-> (rsp_data.packet_id_res == 16'd0))
      else $error("token event with nonzero packet id");

   // A non-last beat is followed by a release
   a_follow_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |=> (rsp_data.event_res == EV_RELEASED))
      else $error("burst continues with something other than a release");

endmodule

bind token_bucket_packet_shaper_top tbps_checker u_tbps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
